// ----- sv/line_segment_clipper_macros.svh -----
// assertion macros used by the checker
`ifndef LINE_SEGMENT_CLIPPER_MACROS_SVH
`define LINE_SEGMENT_CLIPPER_MACROS_SVH

// same-cycle implication, clocked on clk and held off during reset
`define LSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk and held off during reset
`define LSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lsc_pkg.sv -----
`default_nettype none
package lsc_pkg;

  // default geometry
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // configuration register map
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } cfg_reg_t;

  // how a segment meets one clip edge
  typedef enum logic [1:0] {
    EK_PAR   = 2'd0,
    EK_ENTER = 2'd1,
    EK_LEAVE = 2'd2
  } edge_kind_t;

  // where the crossing ratio q/p falls relative to [0, 1]
  typedef enum logic [2:0] {
    RC_NEG  = 3'd0,
    RC_ZERO = 3'd1,
    RC_FRAC = 3'd2,
    RC_ONE  = 3'd3,
    RC_OVER = 3'd4
  } ratio_class_t;

  // per-edge control carried alongside the divider
  typedef struct packed {
    edge_kind_t   kind;
    logic         par_rej;
    ratio_class_t cls;
  } lsc_edge_ctl_t;

endpackage
`default_nettype wire

// ----- sv/lsc_setup.sv -----
`default_nettype none
module lsc_setup #(
  parameter int CW = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic signed [CW-1:0]          sx,
  input  logic signed [CW-1:0]          sy,
  input  logic signed [CW-1:0]          ex,
  input  logic signed [CW-1:0]          ey,
  input  logic signed [CW-1:0]          wl,
  input  logic signed [CW-1:0]          wr,
  input  logic signed [CW-1:0]          wb,
  input  logic signed [CW-1:0]          wt,
  output logic                          vld,
  output logic signed [CW-1:0]          x0,
  output logic signed [CW-1:0]          y0,
  output logic signed [CW:0]            dx,
  output logic signed [CW:0]            dy,
  output lsc_pkg::lsc_edge_ctl_t [3:0]  ctl,
  output logic [3:0][CW-1:0]            num,
  output logic [3:0][CW-1:0]            den
);
  import lsc_pkg::*;

  logic signed [CW:0]   dx_c, dy_c;
  logic signed [CW:0]   p_c [4];
  logic signed [CW:0]   q_c [4];
  logic signed [CW+1:0] n_c [4];
  logic signed [CW+1:0] dext_c [4];
  logic [CW:0]          pabs_c [4];
  lsc_edge_ctl_t [3:0]  ctl_c;
  logic [3:0][CW-1:0]   num_c, den_c;

  // edge terms and ratio classification
  always_comb begin
    dx_c = $signed({ex[CW-1], ex}) - $signed({sx[CW-1], sx});
    dy_c = $signed({ey[CW-1], ey}) - $signed({sy[CW-1], sy});
    p_c[0] = -dx_c;
    p_c[1] = dx_c;
    p_c[2] = -dy_c;
    p_c[3] = dy_c;
    q_c[0] = $signed({sx[CW-1], sx}) - $signed({wl[CW-1], wl});
    q_c[1] = $signed({wr[CW-1], wr}) - $signed({sx[CW-1], sx});
    q_c[2] = $signed({sy[CW-1], sy}) - $signed({wb[CW-1], wb});
    q_c[3] = $signed({wt[CW-1], wt}) - $signed({sy[CW-1], sy});
    for (int e = 0; e < 4; e++) begin
      pabs_c[e] = p_c[e][CW] ? -p_c[e] : p_c[e];
      n_c[e]    = p_c[e][CW] ? -$signed({q_c[e][CW], q_c[e]}) : $signed({q_c[e][CW], q_c[e]});
      dext_c[e] = $signed({2'b00, pabs_c[e][CW-1:0]});
      ctl_c[e].par_rej = q_c[e][CW];
      num_c[e] = '0;
      den_c[e] = pabs_c[e][CW-1:0];
      if (p_c[e] == '0) begin
        ctl_c[e].kind = EK_PAR;
      end else if (p_c[e][CW]) begin
        ctl_c[e].kind = EK_ENTER;
      end else begin
        ctl_c[e].kind = EK_LEAVE;
      end
      if (n_c[e] < 0) begin
        ctl_c[e].cls = RC_NEG;
      end else if (n_c[e] == '0) begin
        ctl_c[e].cls = RC_ZERO;
      end else if (n_c[e] == dext_c[e]) begin
        ctl_c[e].cls = RC_ONE;
      end else if (n_c[e] > dext_c[e]) begin
        ctl_c[e].cls = RC_OVER;
      end else begin
        ctl_c[e].cls = RC_FRAC;
        num_c[e] = n_c[e][CW-1:0];
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= in_vld;
    end
    x0  <= sx;
    y0  <= sy;
    dx  <= dx_c;
    dy  <= dy_c;
    ctl <= ctl_c;
    num <= num_c;
    den <= den_c;
  end

endmodule
`default_nettype wire

// ----- sv/lsc_div_step.sv -----
`default_nettype none
module lsc_div_step #(
  parameter int CW = 16,
  parameter int F  = 16,
  parameter int SW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vld_i,
  input  logic [SW-1:0]      side_i,
  input  logic [3:0][CW-1:0] rem_i,
  input  logic [3:0][CW-1:0] den_i,
  input  logic [3:0][F-1:0]  quo_i,
  output logic               vld_o,
  output logic [SW-1:0]      side_o,
  output logic [3:0][CW-1:0] rem_o,
  output logic [3:0][CW-1:0] den_o,
  output logic [3:0][F-1:0]  quo_o
);

  logic [CW:0]        r2 [4];
  logic [CW:0]        diff [4];
  logic [3:0]         ge;
  logic [3:0][CW-1:0] rem_c;
  logic [3:0][F-1:0]  quo_c;

  // one restoring quotient bit for each edge
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      r2[e]    = {rem_i[e], 1'b0};
      ge[e]    = r2[e] >= {1'b0, den_i[e]};
      diff[e]  = r2[e] - {1'b0, den_i[e]};
      rem_c[e] = ge[e] ? diff[e][CW-1:0] : r2[e][CW-1:0];
      quo_c[e] = {quo_i[e][F-2:0], ge[e]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
    side_o <= side_i;
    rem_o  <= rem_c;
    den_o  <= den_i;
    quo_o  <= quo_c;
  end

endmodule
`default_nettype wire

// ----- sv/lsc_walk.sv -----
`default_nettype none
module lsc_walk #(
  parameter int CW = 16,
  parameter int F  = 16,
  parameter int PW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         vld_i,
  input  logic [PW-1:0]                pass_i,
  input  lsc_pkg::lsc_edge_ctl_t [3:0] ctl_i,
  input  logic [3:0][CW-1:0]           rem_i,
  input  logic [3:0][CW-1:0]           den_i,
  input  logic [3:0][F-1:0]            quo_i,
  output logic                         vld_o,
  output logic                         ok_o,
  output logic [F:0]                   t0_o,
  output logic [F:0]                   t1_o,
  output logic [PW-1:0]                pass_o
);
  import lsc_pkg::*;

  localparam int KW = F + 3;
  localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

  logic [3:0][KW-1:0] key_c;
  logic [3:0][F:0]    rnd_c;
  logic [3:0]         rup_c;

  // exact comparison key (doubled quotient plus sticky) and rounded ratio
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      rup_c[e] = {rem_i[e], 1'b0} >= {1'b0, den_i[e]};
      unique case (ctl_i[e].cls)
        RC_NEG: begin
          key_c[e] = '1;
          rnd_c[e] = '0;
        end
        RC_ZERO: begin
          key_c[e] = '0;
          rnd_c[e] = '0;
        end
        RC_FRAC: begin
          key_c[e] = {2'b00, quo_i[e], rem_i[e] != '0};
          rnd_c[e] = {1'b0, quo_i[e]} + {{F{1'b0}}, rup_c[e]};
        end
        RC_ONE: begin
          key_c[e] = {2'b01, {(F+1){1'b0}}};
          rnd_c[e] = T_ONE;
        end
        RC_OVER: begin
          key_c[e] = {2'b01, {F{1'b0}}, 1'b1};
          rnd_c[e] = T_ONE;
        end
        default: begin
          key_c[e] = '0;
          rnd_c[e] = '0;
        end
      endcase
    end
  end

  logic                vld_s  [5];
  logic                ok_s   [5];
  logic [F:0]          t0_s   [5];
  logic [F:0]          t1_s   [5];
  logic [PW-1:0]       pass_s [5];
  lsc_edge_ctl_t [3:0] ctl_s  [5];
  logic [3:0][KW-1:0]  key_s  [5];
  logic [3:0][F:0]     rnd_s  [5];

  // key stage, t0 = 0 and t1 = 1 on entry
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else begin
      vld_s[0] <= vld_i;
    end
    ok_s[0]   <= 1'b1;
    t0_s[0]   <= '0;
    t1_s[0]   <= T_ONE;
    pass_s[0] <= pass_i;
    ctl_s[0]  <= ctl_i;
    key_s[0]  <= key_c;
    rnd_s[0]  <= rnd_c;
  end

  // one edge per stage: left, right, bottom, top
  for (genvar g = 0; g < 4; g++) begin : g_edge
    logic              ok_n;
    logic [F:0]        t0_n, t1_n;
    logic signed [KW-1:0] k, k0, k1;

    always_comb begin
      ok_n = ok_s[g];
      t0_n = t0_s[g];
      t1_n = t1_s[g];
      k    = $signed(key_s[g][g]);
      k0   = $signed({1'b0, t0_s[g], 1'b0});
      k1   = $signed({1'b0, t1_s[g], 1'b0});
      if (ok_s[g]) begin
        unique case (ctl_s[g][g].kind)
          EK_PAR: begin
            if (ctl_s[g][g].par_rej) ok_n = 1'b0;
          end
          EK_ENTER: begin
            if (k > k1) begin
              ok_n = 1'b0;
            end else if (k > k0) begin
              t0_n = rnd_s[g][g];
            end
          end
          EK_LEAVE: begin
            if (k < k0) begin
              ok_n = 1'b0;
            end else if (k < k1) begin
              t1_n = rnd_s[g][g];
            end
          end
          default: ok_n = ok_s[g];
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else begin
        vld_s[g+1] <= vld_s[g];
      end
      ok_s[g+1]   <= ok_n;
      t0_s[g+1]   <= t0_n;
      t1_s[g+1]   <= t1_n;
      pass_s[g+1] <= pass_s[g];
      ctl_s[g+1]  <= ctl_s[g];
      key_s[g+1]  <= key_s[g];
      rnd_s[g+1]  <= rnd_s[g];
    end
  end

  assign vld_o  = vld_s[4];
  assign ok_o   = ok_s[4];
  assign t0_o   = t0_s[4];
  assign t1_o   = t1_s[4];
  assign pass_o = pass_s[4];

endmodule
`default_nettype wire

// ----- sv/lsc_place.sv -----
`default_nettype none
module lsc_place #(
  parameter int CW = 16,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_i,
  input  logic                 ok_i,
  input  logic [F:0]           t0_i,
  input  logic [F:0]           t1_i,
  input  logic signed [CW-1:0] x0_i,
  input  logic signed [CW-1:0] y0_i,
  input  logic signed [CW:0]   dx_i,
  input  logic signed [CW:0]   dy_i,
  output logic                 done,
  output logic                 visible,
  output logic signed [CW-1:0] cx0,
  output logic signed [CW-1:0] cy0,
  output logic signed [CW-1:0] cx1,
  output logic signed [CW-1:0] cy1
);

  localparam int PW = CW + F + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  logic [CW:0]   ax, ay;
  logic [CW-1:0] mx, my;

  // magnitudes of the deltas
  always_comb begin
    ax = dx_i[CW] ? -dx_i : dx_i;
    ay = dy_i[CW] ? -dy_i : dy_i;
    mx = ax[CW-1:0];
    my = ay[CW-1:0];
  end

  logic                 vld_m, ok_m, nx_m, ny_m;
  logic signed [CW-1:0] x0_m, y0_m;
  logic [PW-1:0]        px0_m, py0_m, px1_m, py1_m;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
    end else begin
      vld_m <= vld_i;
    end
    ok_m  <= ok_i;
    nx_m  <= dx_i[CW];
    ny_m  <= dy_i[CW];
    x0_m  <= x0_i;
    y0_m  <= y0_i;
    px0_m <= PW'(mx) * PW'(t0_i);
    py0_m <= PW'(my) * PW'(t0_i);
    px1_m <= PW'(mx) * PW'(t1_i);
    py1_m <= PW'(my) * PW'(t1_i);
  end

  function automatic logic [CW-1:0] apply(input logic [CW-1:0] base, input logic neg,
                                          input logic [PW-1:0] prod);
    logic [PW-1:0] sum;
    logic [CW:0]   off, res;
    sum = prod + HALF;
    off = {1'b0, sum[F +: CW]};
    res = neg ? ({1'b0, base} - off) : ({1'b0, base} + off);
    return res[CW-1:0];
  endfunction

  // rounding, offset and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_m;
    end
    visible <= ok_m;
    cx0 <= ok_m ? $signed(apply(x0_m, nx_m, px0_m)) : '0;
    cy0 <= ok_m ? $signed(apply(y0_m, ny_m, py0_m)) : '0;
    cx1 <= ok_m ? $signed(apply(x0_m, nx_m, px1_m)) : '0;
    cy1 <= ok_m ? $signed(apply(y0_m, ny_m, py1_m)) : '0;
  end

endmodule
`default_nettype wire

// ----- sv/line_segment_clipper.sv -----
// Liang-Barsky segment clipper, fully pipelined.
// From start to done a segment passes the setup register, the divider steps, the walk stages and the place registers.
// Throughput: one segment every cycle; the divider is one quotient bit per stage.
// Reset: window returns to left/bottom 0, right/top at the largest positive value;
// all pipeline valid bits clear and busy is registered: high through reset, clearing in the cycle after it.
`default_nettype none
module line_segment_clipper #(
  parameter int COORD_WIDTH   = lsc_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = lsc_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_WIDTH-1:0]   start_x,
  input  logic signed [COORD_WIDTH-1:0]   start_y,
  input  logic signed [COORD_WIDTH-1:0]   end_x,
  input  logic signed [COORD_WIDTH-1:0]   end_y,
  output logic                            done,
  output logic                            visible,
  output logic signed [COORD_WIDTH-1:0]   clipped_start_x,
  output logic signed [COORD_WIDTH-1:0]   clipped_start_y,
  output logic signed [COORD_WIDTH-1:0]   clipped_end_x,
  output logic signed [COORD_WIDTH-1:0]   clipped_end_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data
);
  import lsc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * CW + 2 * (CW + 1);
  localparam int SW = PW + 4 * $bits(lsc_edge_ctl_t);
  localparam logic signed [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};

  logic signed [CW-1:0] win_left, win_right, win_bottom, win_top;

  // busy through reset and the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // window registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_right  <= POS_MAX;
      win_bottom <= '0;
      win_top    <= POS_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT:   win_left   <= $signed(cfg_data);
        REG_RIGHT:  win_right  <= $signed(cfg_data);
        REG_BOTTOM: win_bottom <= $signed(cfg_data);
        REG_TOP:    win_top    <= $signed(cfg_data);
        default:    win_left   <= win_left;
      endcase
    end
  end

  logic                 s_vld;
  logic signed [CW-1:0] s_x0, s_y0;
  logic signed [CW:0]   s_dx, s_dy;
  lsc_edge_ctl_t [3:0]  s_ctl;
  logic [3:0][CW-1:0]   s_num, s_den;

  // edge terms
  lsc_setup #(.CW(CW)) u_setup (
    .clk(clk), .rst(rst), .in_vld(start && !busy),
    .sx(start_x), .sy(start_y), .ex(end_x), .ey(end_y),
    .wl(win_left), .wr(win_right), .wb(win_bottom), .wt(win_top),
    .vld(s_vld), .x0(s_x0), .y0(s_y0), .dx(s_dx), .dy(s_dy),
    .ctl(s_ctl), .num(s_num), .den(s_den)
  );

  logic               d_vld  [F+1];
  logic [SW-1:0]      d_side [F+1];
  logic [3:0][CW-1:0] d_rem  [F+1];
  logic [3:0][CW-1:0] d_den  [F+1];
  logic [3:0][F-1:0]  d_quo  [F+1];

  assign d_vld[0]  = s_vld;
  assign d_side[0] = {s_x0, s_y0, s_dx, s_dy, s_ctl};
  assign d_rem[0]  = s_num;
  assign d_den[0]  = s_den;
  assign d_quo[0]  = '0;

  // divider, one quotient bit per stage
  for (genvar i = 0; i < F; i++) begin : g_div
    lsc_div_step #(.CW(CW), .F(F), .SW(SW)) u_step (
      .clk(clk), .rst(rst),
      .vld_i(d_vld[i]), .side_i(d_side[i]), .rem_i(d_rem[i]),
      .den_i(d_den[i]), .quo_i(d_quo[i]),
      .vld_o(d_vld[i+1]), .side_o(d_side[i+1]), .rem_o(d_rem[i+1]),
      .den_o(d_den[i+1]), .quo_o(d_quo[i+1])
    );
  end

  logic                 w_vld, w_ok;
  logic [F:0]           w_t0, w_t1;
  logic [PW-1:0]        w_pass;
  logic signed [CW-1:0] w_x0, w_y0;
  logic signed [CW:0]   w_dx, w_dy;

  // edge walk over t0 and t1
  lsc_walk #(.CW(CW), .F(F), .PW(PW)) u_walk (
    .clk(clk), .rst(rst),
    .vld_i(d_vld[F]), .pass_i(d_side[F][SW-1 -: PW]),
    .ctl_i(d_side[F][4*$bits(lsc_edge_ctl_t)-1:0]),
    .rem_i(d_rem[F]), .den_i(d_den[F]), .quo_i(d_quo[F]),
    .vld_o(w_vld), .ok_o(w_ok), .t0_o(w_t0), .t1_o(w_t1), .pass_o(w_pass)
  );

  assign {w_x0, w_y0, w_dx, w_dy} = w_pass;

  // endpoint placement
  lsc_place #(.CW(CW), .F(F)) u_place (
    .clk(clk), .rst(rst),
    .vld_i(w_vld), .ok_i(w_ok), .t0_i(w_t0), .t1_i(w_t1),
    .x0_i(w_x0), .y0_i(w_y0), .dx_i(w_dx), .dy_i(w_dy),
    .done(done), .visible(visible),
    .cx0(clipped_start_x), .cy0(clipped_start_y),
    .cx1(clipped_end_x), .cy1(clipped_end_y)
  );

endmodule
`default_nettype wire

// ----- sv/lsc_checker.sv -----
`default_nettype none
`include "line_segment_clipper_macros.svh"
module lsc_checker #(
  parameter int COORD_WIDTH   = lsc_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = lsc_pkg::FRACTION_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic signed [COORD_WIDTH-1:0]   start_x,
  input logic signed [COORD_WIDTH-1:0]   start_y,
  input logic signed [COORD_WIDTH-1:0]   end_x,
  input logic signed [COORD_WIDTH-1:0]   end_y,
  input logic                            done,
  input logic                            visible,
  input logic signed [COORD_WIDTH-1:0]   clipped_start_x,
  input logic signed [COORD_WIDTH-1:0]   clipped_start_y,
  input logic signed [COORD_WIDTH-1:0]   clipped_end_x,
  input logic signed [COORD_WIDTH-1:0]   clipped_end_y,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [lsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [COORD_WIDTH-1:0]          cfg_data
);

  localparam int LAT = FRACTION_BITS + 8;

  // busy drops once reset is gone
  `LSC_ASSERT_NXT(a_busy_clear, 1'b1, !busy, "busy high after reset")

  // every word out traces back to a segment taken in by start while not busy
  `LSC_ASSERT_IMP(a_latency, done, $past(start && !busy, LAT), "word without a segment")

  // rejected segments report zero coordinates
  `LSC_ASSERT_IMP(a_zero_hidden, done && !visible, (clipped_start_x == 0) && (clipped_start_y == 0) && (clipped_end_x == 0) && (clipped_end_y == 0), "hidden segment not zeroed")

  // clipped start x stays between the original endpoints
  `LSC_ASSERT_IMP(a_x_span, done && visible, ((clipped_start_x >= $past(start_x, LAT)) && (clipped_start_x <= $past(end_x, LAT))) || ((clipped_start_x <= $past(start_x, LAT)) && (clipped_start_x >= $past(end_x, LAT))), "clipped x outside segment")

endmodule

bind line_segment_clipper lsc_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRACTION_BITS(FRACTION_BITS)
) u_lsc_checker (.*);
`default_nettype wire
